FILE: rtl/plcm_pkg.sv
// shared types, constants and reset table of the piecewise linear color map
`timescale 1ns / 1ps

package plcm_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 4;
    localparam int CH_W       = 8;
    localparam int PROD_W     = 2 * CH_W;
    localparam int REM_W      = PROD_W + 1;
    localparam int DIV_W      = CH_W + 1;
    localparam int DIV_STAGES = 4;
    localparam int BITS_PER_STAGE = CH_W / DIV_STAGES;
    localparam int LAT_LERP   = DIV_STAGES + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] pos;
        logic [CH_W-1:0] opa;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] grn;
        logic [CH_W-1:0] blu;
    } point_t;

    // interpolation fraction shared by all four channels
    typedef struct packed {
        logic [CH_W-1:0] num;
        logic [CH_W-1:0] den;
    } frac_t;

    function automatic point_t default_point(input int idx);
        point_t p;
        p = '0;
        unique case (idx)
            1: p.pos = 8'd102;
            2: p = '{pos: 8'd128, opa: 8'd128, red: 8'd255, grn: 8'd128, blu: 8'd0};
            3: p = '{pos: 8'd255, opa: 8'd255, red: 8'd255, grn: 8'd255, blu: 8'd255};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/plcm_if.sv
// item channels of the color map: request in, rgba result out
`timescale 1ns / 1ps

interface plcm_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] point_index;
    logic [7:0] point_position;
    logic [7:0] point_opacity;
    logic [7:0] point_red;
    logic [7:0] point_green;
    logic [7:0] point_blue;
    logic [7:0] sample_value;

    modport source (output valid, op, point_index, point_position, point_opacity,
                    point_red, point_green, point_blue, sample_value, input ready);
    modport sink (input valid, op, point_index, point_position, point_opacity,
                  point_red, point_green, point_blue, sample_value, output ready);
endinterface

interface plcm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_opacity;

    modport source (output valid, out_red, out_green, out_blue, out_opacity, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_opacity, output ready);
endinterface

FILE: rtl/piecewise_linear_color_map_core.sv
// top level of the piecewise linear color map
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    op, point_index, point_*, sample_value
//  rsp      out  valid/ready    out_red, out_green, out_blue, out_opacity
//  cfg      in   cfg_we         cfg_wdata = active_points
//
// one item per cycle unless the result stalls; a sample result passes through
// input, search, product, four divider stages and output register
// a point write updates the table at acceptance and yields no result
// reset loads the default four-point ramp and active_points = 4
// a stalled result freezes the whole pipeline; req.ready follows it
`timescale 1ns / 1ps

module piecewise_linear_color_map_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    plcm_req_if.sink                      req,
    plcm_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [plcm_pkg::CNT_W-1:0]    cfg_wdata
);

    localparam int NV = plcm_pkg::LAT_LERP;

    plcm_pkg::point_t                 tbl_reg [plcm_pkg::MAX_POINTS];
    logic [plcm_pkg::CNT_W-1:0]       active_reg;
    logic                             en;
    logic                             acc;

    // input stage
    logic                             v0_reg;
    logic [plcm_pkg::CH_W-1:0]        s_reg;

    // search stage
    logic                             v1_reg;
    plcm_pkg::point_t                 lp_reg, rp_reg, lp_next, rp_next;
    plcm_pkg::frac_t                  frac_reg, frac_next;

    logic [NV-1:0]                    vl_reg;
    logic                             out_valid_reg;
    logic [plcm_pkg::CH_W-1:0]        red_reg, grn_reg, blu_reg, opa_reg;
    logic [plcm_pkg::CH_W-1:0]        red_w, grn_w, blu_w, opa_w;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;
    assign acc       = req.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= plcm_pkg::CNT_W'(4);
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    for (genvar i = 0; i < plcm_pkg::MAX_POINTS; i++)
    begin : g_tbl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tbl_reg[i] <= plcm_pkg::default_point(i);
            end
            else if (acc && req.op == plcm_pkg::OP_WRITE
                     && req.point_index == plcm_pkg::IDX_W'(i))
            begin
                tbl_reg[i] <= '{pos: req.point_position, opa: req.point_opacity,
                                red: req.point_red, grn: req.point_green,
                                blu: req.point_blue};
            end
        end
    end

    // priority scan for the first point above the sample
    always_comb
    begin
        logic [plcm_pkg::CNT_W-1:0] cnt;
        logic [plcm_pkg::IDX_W-1:0] ri, li;
        logic                       found;
        cnt = active_reg;
        if (cnt == '0)
        begin
            cnt = plcm_pkg::CNT_W'(1);
        end
        else if (cnt > plcm_pkg::CNT_W'(plcm_pkg::MAX_POINTS))
        begin
            cnt = plcm_pkg::CNT_W'(plcm_pkg::MAX_POINTS);
        end
        found = 1'b0;
        ri    = '0;
        for (int i = 0; i < plcm_pkg::MAX_POINTS; i++)
        begin
            if (!found && plcm_pkg::CNT_W'(i) < cnt && tbl_reg[i].pos > s_reg)
            begin
                ri    = plcm_pkg::IDX_W'(i);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            li = plcm_pkg::IDX_W'(cnt - plcm_pkg::CNT_W'(1));
            ri = li;
        end
        else if (ri == '0)
        begin
            li = '0;
        end
        else
        begin
            li = ri - plcm_pkg::IDX_W'(1);
        end
        lp_next = tbl_reg[li];
        rp_next = tbl_reg[ri];
        if (rp_next.pos > lp_next.pos && s_reg >= lp_next.pos)
        begin
            frac_next.den = rp_next.pos - lp_next.pos;
            frac_next.num = s_reg - lp_next.pos;
            if (frac_next.num > frac_next.den)
            begin
                frac_next.num = frac_next.den;
            end
        end
        else
        begin
            frac_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            vl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= acc && req.op == plcm_pkg::OP_SAMPLE;
            v1_reg        <= v0_reg;
            vl_reg        <= {vl_reg[NV-2:0], v1_reg};
            out_valid_reg <= vl_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= req.sample_value;
            lp_reg   <= lp_next;
            rp_reg   <= rp_next;
            frac_reg <= frac_next;
            red_reg  <= red_w;
            grn_reg  <= grn_w;
            blu_reg  <= blu_w;
            opa_reg  <= opa_w;
        end
    end

    plcm_lerp u_red (.clk(clk), .en(en), .lo(lp_reg.red), .hi(rp_reg.red),
                     .frac(frac_reg), .value(red_w));
    plcm_lerp u_grn (.clk(clk), .en(en), .lo(lp_reg.grn), .hi(rp_reg.grn),
                     .frac(frac_reg), .value(grn_w));
    plcm_lerp u_blu (.clk(clk), .en(en), .lo(lp_reg.blu), .hi(rp_reg.blu),
                     .frac(frac_reg), .value(blu_w));
    plcm_lerp u_opa (.clk(clk), .en(en), .lo(lp_reg.opa), .hi(rp_reg.opa),
                     .frac(frac_reg), .value(opa_w));

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_red     = red_reg;
    assign rsp.out_green   = grn_reg;
    assign rsp.out_blue    = blu_reg;
    assign rsp.out_opacity = opa_reg;

endmodule

FILE: rtl/plcm_lerp.sv
// one channel: product stage then a 2-bit-per-stage restoring divider
`timescale 1ns / 1ps

module plcm_lerp
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [plcm_pkg::CH_W-1:0]  lo,
    input  logic [plcm_pkg::CH_W-1:0]  hi,
    input  plcm_pkg::frac_t            frac,
    output logic [plcm_pkg::CH_W-1:0]  value
);

    logic [plcm_pkg::REM_W-1:0]  rem_reg [0:plcm_pkg::DIV_STAGES];
    logic [plcm_pkg::REM_W-1:0]  rem_next [0:plcm_pkg::DIV_STAGES];
    logic [plcm_pkg::DIV_W-1:0]  div_reg [0:plcm_pkg::DIV_STAGES];
    logic [plcm_pkg::CH_W-1:0]   q_reg [0:plcm_pkg::DIV_STAGES];
    logic [plcm_pkg::CH_W-1:0]   q_next [0:plcm_pkg::DIV_STAGES];
    logic [plcm_pkg::CH_W-1:0]   lo_reg [0:plcm_pkg::DIV_STAGES];
    logic                        neg_reg [0:plcm_pkg::DIV_STAGES];

    logic                        neg_next;
    logic [plcm_pkg::CH_W-1:0]   mag;
    logic [plcm_pkg::PROD_W-1:0] prod;
    logic [plcm_pkg::DIV_W-1:0]  div_next;

    // rounded quotient (2*mag*num + den) / (2*den); den of zero gives q of zero
    always_comb
    begin
        neg_next    = hi < lo;
        mag         = neg_next ? (lo - hi) : (hi - lo);
        prod        = mag * frac.num;
        rem_next[0] = {prod, 1'b0} + plcm_pkg::REM_W'(frac.den);
        q_next[0]   = '0;
        div_next    = (frac.den == '0) ? plcm_pkg::DIV_W'(1) : {frac.den, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            div_reg[0] <= div_next;
            q_reg[0]   <= q_next[0];
            lo_reg[0]  <= lo;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar j = 0; j < plcm_pkg::DIV_STAGES; j++)
    begin : g_div
        always_comb
        begin
            logic [plcm_pkg::REM_W-1:0] r;
            logic [plcm_pkg::REM_W-1:0] sh;
            logic [plcm_pkg::CH_W-1:0]  q;
            r = rem_reg[j];
            q = q_reg[j];
            for (int b = 0; b < plcm_pkg::BITS_PER_STAGE; b++)
            begin
                sh = plcm_pkg::REM_W'(div_reg[j])
                     << (plcm_pkg::CH_W - 1 - j * plcm_pkg::BITS_PER_STAGE - b);
                if (r >= sh)
                begin
                    r = r - sh;
                    q[plcm_pkg::CH_W - 1 - j * plcm_pkg::BITS_PER_STAGE - b] = 1'b1;
                end
            end
            rem_next[j+1] = r;
            q_next[j+1]   = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= rem_next[j+1];
                div_reg[j+1] <= div_reg[j];
                q_reg[j+1]   <= q_next[j+1];
                lo_reg[j+1]  <= lo_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign value = neg_reg[plcm_pkg::DIV_STAGES]
                 ? lo_reg[plcm_pkg::DIV_STAGES] - q_reg[plcm_pkg::DIV_STAGES]
                 : lo_reg[plcm_pkg::DIV_STAGES] + q_reg[plcm_pkg::DIV_STAGES];

endmodule

FILE: rtl/plcm_chk.sv
// port-level checks of the color map and their binding
`timescale 1ns / 1ps

module plcm_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_red,
    input logic [7:0] rsp_opacity
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_opacity))
        else $error("result changed while stalled");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("item taken while result stalled");

    a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("pipeline blocked with empty output");

endmodule

bind piecewise_linear_color_map_core plcm_chk u_plcm_chk
(
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_red(rsp.out_red),
    .rsp_opacity(rsp.out_opacity)
);
